// ----- sv/acsc_pkg.sv -----
// ----------------------------------------------------------------------------
// acsc_pkg: shared definitions of the adaptive crop size controller
// Widths, register codes and the command and status groups that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package acsc_pkg;

    localparam int COORD_BITS = 12;
    localparam int WIN_BITS   = COORD_BITS + 1;
    localparam int SIZE_W     = 13;
    localparam int ALPHA_W    = 9;
    localparam int GAIN_W     = 16;
    localparam int MARGIN_W   = 7;
    localparam int FRAC_W     = 8;

    localparam int IN_FIELD_BITS = 6 * COORD_BITS + 2 * WIN_BITS;
    localparam int IN_TDATA_W    = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W   = ((SIZE_W + 7) / 8) * 8;

    localparam int NUM_REGS = 7;
    localparam int ADDR_W   = $clog2(NUM_REGS * 4);
    localparam int APB_DW   = 32;

    // Datapath widths.
    localparam int MX_W    = WIN_BITS + MARGIN_W;
    localparam int EDGE_W  = WIN_BITS + FRAC_W + 2;
    localparam int RAW_W   = COORD_BITS + GAIN_W;
    localparam int FLOOR_W = SIZE_W + 3 + FRAC_W;
    localparam int DES_W   = (RAW_W > FLOOR_W) ? RAW_W + 1 : FLOOR_W + 1;
    localparam int DQ_W    = SIZE_W + FRAC_W;
    localparam int DIFF_W  = DQ_W + 1;
    localparam int PR_W    = DIFF_W + ALPHA_W + 1;
    localparam int SM_W    = SIZE_W + 16;
    localparam int Q_W     = SIZE_W + 1;
    localparam int CNT_W   = $clog2(Q_W);
    localparam int RES_W   = Q_W + 2;

    localparam logic [ALPHA_W-1:0]  ALPHA_ONE  = ALPHA_W'(256);
    localparam logic [MARGIN_W-1:0] MARGIN_MAX = MARGIN_W'(125);
    localparam int                  EDGE_STEPS = 4;

    typedef enum logic [2:0] {
        REG_MIN_SIDE    = 3'd0,
        REG_MAX_SIDE    = 3'd1,
        REG_SEARCH_SIDE = 3'd2,
        REG_STEP_PX     = 3'd3,
        REG_ALPHA_Q8    = 3'd4,
        REG_GAIN_Q8     = 3'd5,
        REG_MARGIN_Q8   = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [SIZE_W-1:0]   min_side;
        logic [SIZE_W-1:0]   max_side;
        logic [SIZE_W-1:0]   search_side;
        logic [SIZE_W-1:0]   step_px;
        logic [ALPHA_W-1:0]  alpha_q8;
        logic [GAIN_W-1:0]   gain_q8;
        logic [MARGIN_W-1:0] margin_q8;
    } cfg_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] box_left;
        logic [COORD_BITS-1:0] box_top;
        logic [COORD_BITS-1:0] box_right;
        logic [COORD_BITS-1:0] box_bottom;
        logic [COORD_BITS-1:0] win_left;
        logic [COORD_BITS-1:0] win_top;
        logic [WIN_BITS-1:0]   win_width;
        logic [WIN_BITS-1:0]   win_height;
        logic                  has_target;
    } item_t;

    typedef struct packed {
        logic capture;
        logic box_en;
        logic mul_en;
        logic clamp_en;
        logic smooth_en;
        logic round_en;
        logic div_en;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic unit_step;
        logic div_last;
    } sts_t;

endpackage

// ----- sv/acsc_ctrl.sv -----
// ----------------------------------------------------------------------------
// acsc_ctrl: sequencer of the crop size controller
// Walks one request through the datapath stages and, unless the step is 1,
// the remainder divider, then hands the result to the output register.
// ----------------------------------------------------------------------------
module acsc_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic          out_free,
    input  acsc_pkg::sts_t sts,
    output acsc_pkg::cmd_t cmd
);
    import acsc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BOX,
        ST_MUL,
        ST_CLAMP,
        ST_SMOOTH,
        ST_ROUND,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.capture = s_tvalid;
                if (s_tvalid) state_next = ST_BOX;
            end
            ST_BOX: begin
                cmd.box_en = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = ST_CLAMP;
            end
            ST_CLAMP: begin
                cmd.clamp_en = 1'b1;
                state_next   = ST_SMOOTH;
            end
            ST_SMOOTH: begin
                cmd.smooth_en = 1'b1;
                state_next    = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round_en = 1'b1;
                state_next   = sts.unit_step ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
                cmd.div_en = 1'b1;
                if (sts.div_last) state_next = ST_DONE;
            end
            ST_DONE: begin
                cmd.finish = out_free;
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

// ----- sv/acsc_dp.sv -----
// ----------------------------------------------------------------------------
// acsc_dp: datapath of the crop size controller
// Box side and gain, edge rule, clamping, smoothing, and rounding to the step
// grid, through a one-bit-per-cycle remainder divider unless the step is 1.
// ----------------------------------------------------------------------------
module acsc_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  acsc_pkg::cfg_t                cfg,
    input  acsc_pkg::item_t               item,
    input  acsc_pkg::cmd_t                cmd,
    output acsc_pkg::sts_t                sts,
    output logic [acsc_pkg::SIZE_W-1:0]   crop_size
);
    import acsc_pkg::*;

    // Effective configuration.
    logic [SIZE_W-1:0]   lo, hi, srch, step_e;
    logic [ALPHA_W-1:0]  alpha_e;
    logic [MARGIN_W-1:0] m_e;

    always_comb begin
        lo      = (cfg.min_side == '0) ? SIZE_W'(1) : cfg.min_side;
        hi      = (cfg.max_side < lo) ? lo : cfg.max_side;
        srch    = (cfg.search_side < lo) ? lo :
                  (cfg.search_side > hi) ? hi : cfg.search_side;
        step_e  = (cfg.step_px == '0) ? SIZE_W'(1) : cfg.step_px;
        alpha_e = (cfg.alpha_q8 > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha_q8;
        m_e     = (cfg.margin_q8 > MARGIN_MAX) ? MARGIN_MAX : cfg.margin_q8;
    end

    item_t                 item_reg;
    logic [SIZE_W-1:0]     current_reg;
    logic [SIZE_W-1:0]     cur_reg;
    logic [COORD_BITS-1:0] side_reg;
    logic [MX_W-1:0]       mx_reg, my_reg;
    logic                  edge_en_reg;
    logic [RAW_W-1:0]      raw_reg;
    logic [FLOOR_W-1:0]    floor_reg;
    logic                  near_reg;
    logic [DQ_W-1:0]       dq_reg;
    logic [SM_W-1:0]       smooth_reg;
    logic [Q_W-1:0]        q_reg, unit_res_reg, dvd_reg;
    logic                  neg_reg;
    logic [SIZE_W-1:0]     rem_reg;
    logic [CNT_W-1:0]      cnt_reg;

    // Box stage.
    logic signed [COORD_BITS:0] bw_s, bh_s;
    logic [COORD_BITS-1:0]      bw, bh, side_next;
    logic [SIZE_W-1:0]          cur_next;

    always_comb begin
        bw_s = $signed({1'b0, item_reg.box_right}) - $signed({1'b0, item_reg.box_left});
        bh_s = $signed({1'b0, item_reg.box_bottom}) - $signed({1'b0, item_reg.box_top});
        // A side of zero or less counts as one pixel.
        bw = (bw_s[COORD_BITS] || bw_s == '0) ? COORD_BITS'(1) : bw_s[COORD_BITS-1:0];
        bh = (bh_s[COORD_BITS] || bh_s == '0) ? COORD_BITS'(1) : bh_s[COORD_BITS-1:0];
        side_next = (bw > bh) ? bw : bh;
        if (current_reg == '0) begin
            cur_next = srch;
        end else if (current_reg < lo) begin
            cur_next = lo;
        end else if (current_reg > hi) begin
            cur_next = hi;
        end else begin
            cur_next = current_reg;
        end
    end

    // Multiply and edge stage.
    logic [EDGE_W-1:0] l_lhs, l_rhs, r_lhs, r_rhs, t_lhs, t_rhs, b_lhs, b_rhs;
    logic              near_next;

    always_comb begin
        l_lhs = EDGE_W'(item_reg.box_left) << FRAC_W;
        l_rhs = (EDGE_W'(item_reg.win_left) << FRAC_W) + EDGE_W'(mx_reg);
        r_lhs = EDGE_W'(item_reg.box_right) << FRAC_W;
        r_rhs = ((EDGE_W'(item_reg.win_left) + EDGE_W'(item_reg.win_width)) << FRAC_W)
                - EDGE_W'(mx_reg);
        t_lhs = EDGE_W'(item_reg.box_top) << FRAC_W;
        t_rhs = (EDGE_W'(item_reg.win_top) << FRAC_W) + EDGE_W'(my_reg);
        b_lhs = EDGE_W'(item_reg.box_bottom) << FRAC_W;
        b_rhs = ((EDGE_W'(item_reg.win_top) + EDGE_W'(item_reg.win_height)) << FRAC_W)
                - EDGE_W'(my_reg);
        near_next = edge_en_reg &&
                    (l_lhs <= l_rhs || r_lhs >= r_rhs || t_lhs <= t_rhs || b_lhs >= b_rhs);
    end

    // Clamp stage.
    logic [DES_W-1:0] des, lo8, hi8;
    logic [DQ_W-1:0]  dq_next;

    always_comb begin
        lo8 = DES_W'(lo) << FRAC_W;
        hi8 = DES_W'(hi) << FRAC_W;
        if (!item_reg.has_target) begin
            des = DES_W'(srch) << FRAC_W;
        end else if (near_reg && DES_W'(raw_reg) < DES_W'(floor_reg)) begin
            des = DES_W'(floor_reg);
        end else begin
            des = DES_W'(raw_reg);
        end
        if (des < lo8) begin
            dq_next = lo8[DQ_W-1:0];
        end else if (des > hi8) begin
            dq_next = hi8[DQ_W-1:0];
        end else begin
            dq_next = des[DQ_W-1:0];
        end
    end

    // Smoothing stage.
    logic signed [DIFF_W-1:0]  diff;
    logic signed [ALPHA_W:0]   alpha_s;
    logic signed [PR_W-1:0]    prod, sm_full;

    always_comb begin
        diff    = $signed({1'b0, dq_reg}) - $signed({1'b0, cur_reg, {FRAC_W{1'b0}}});
        alpha_s = $signed({1'b0, alpha_e});
        prod    = PR_W'(diff) * PR_W'(alpha_s);
        sm_full = $signed(PR_W'({cur_reg, 16'b0})) + prod;
    end

    // Rounding stage: distance from the search size in Q.16, rounded half away
    // from zero; the step division itself is left to the divider.
    logic signed [SM_W:0] off;
    logic [SM_W-1:0]      mag;
    logic [SM_W:0]        qsum, usum;

    always_comb begin
        off  = $signed({1'b0, smooth_reg}) - $signed({1'b0, srch, 16'b0});
        mag  = off[SM_W] ? SM_W'(-off) : off[SM_W-1:0];
        qsum = (SM_W + 1)'(mag) + ((SM_W + 1)'(step_e) << 15);
        usum = (SM_W + 1)'(smooth_reg) + (SM_W + 1)'(32'd32768);
    end

    // Restoring divider, remainder only: n*step equals q minus the remainder.
    logic [Q_W-1:0]    rem_sh;
    logic [SIZE_W-1:0] rem_next;

    always_comb begin
        rem_sh   = {rem_reg, dvd_reg[Q_W-1]};
        rem_next = (rem_sh >= Q_W'(step_e)) ? SIZE_W'(rem_sh - Q_W'(step_e))
                                            : rem_sh[SIZE_W-1:0];
    end

    // Final result.
    logic [Q_W-1:0]          nstep;
    logic signed [RES_W-1:0] res_s, lo_s, hi_s;

    always_comb begin
        nstep = q_reg - Q_W'(rem_reg);
        lo_s  = $signed(RES_W'(lo));
        hi_s  = $signed(RES_W'(hi));
        if (sts.unit_step) begin
            res_s = $signed(RES_W'(unit_res_reg));
        end else if (neg_reg) begin
            res_s = $signed(RES_W'(srch)) - $signed(RES_W'(nstep));
        end else begin
            res_s = $signed(RES_W'(srch)) + $signed(RES_W'(nstep));
        end
        if (res_s < lo_s) begin
            crop_size = lo;
        end else if (res_s > hi_s) begin
            crop_size = hi;
        end else begin
            crop_size = res_s[SIZE_W-1:0];
        end
    end

    assign sts.unit_step = (step_e == SIZE_W'(1));
    assign sts.div_last  = (cnt_reg == CNT_W'(Q_W - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            current_reg <= '0;
        end else if (cmd.finish) begin
            current_reg <= crop_size;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= item;
        end
        if (cmd.box_en) begin
            side_reg    <= side_next;
            cur_reg     <= cur_next;
            mx_reg      <= MX_W'(item_reg.win_width) * MX_W'(m_e);
            my_reg      <= MX_W'(item_reg.win_height) * MX_W'(m_e);
            edge_en_reg <= (item_reg.win_width != '0) && (item_reg.win_height != '0)
                           && (m_e != '0);
        end
        if (cmd.mul_en) begin
            raw_reg   <= RAW_W'(side_reg) * RAW_W'(cfg.gain_q8);
            floor_reg <= (FLOOR_W'(cur_reg) + FLOOR_W'(EDGE_STEPS) * FLOOR_W'(step_e))
                         << FRAC_W;
            near_reg  <= near_next;
        end
        if (cmd.clamp_en) begin
            dq_reg <= dq_next;
        end
        if (cmd.smooth_en) begin
            smooth_reg <= sm_full[SM_W-1:0];
        end
        if (cmd.round_en) begin
            q_reg        <= qsum[SM_W:16];
            dvd_reg      <= qsum[SM_W:16];
            unit_res_reg <= usum[SM_W:16];
            neg_reg      <= off[SM_W];
            rem_reg      <= '0;
            cnt_reg      <= '0;
        end else if (cmd.div_en) begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_reg << 1;
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

endmodule

// ----- sv/adaptive_crop_size_controller.sv -----
// ----------------------------------------------------------------------------
// adaptive_crop_size_controller: per-frame crop side tracking
// Each request passes the box, multiply, clamp, smoothing and rounding states,
// then the remainder divider for the step grid (skipped when the step is 1);
// a new request is accepted only after the last result is in the output register.
// Reset: synchronous active-low aresetn; the configuration registers return
// to their defaults and the current crop side clears to zero, so the first
// frame starts from the search size.
// ----------------------------------------------------------------------------
module adaptive_crop_size_controller (
    input  logic                               aclk,
    input  logic                               aresetn,
    // APB-style configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [acsc_pkg::ADDR_W-1:0]        paddr,
    input  logic [acsc_pkg::APB_DW-1:0]        pwdata,
    output logic [acsc_pkg::APB_DW-1:0]        prdata,
    output logic                               pready,
    // Input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // box_left, box_top, box_right, box_bottom, win_left, win_top,
    // win_width, win_height (from bit 0 up), zero padded
    input  logic [acsc_pkg::IN_TDATA_W-1:0]    s_tdata,
    // has_target
    input  logic                               s_tuser,
    // Result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // crop_size, zero padded
    output logic [acsc_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import acsc_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int WB = WIN_BITS;

    cfg_t              cfg_reg;
    item_t             item;
    cmd_t              cmd;
    sts_t              sts;
    logic [SIZE_W-1:0] crop_size;
    logic              m_tvalid_reg;
    logic [SIZE_W-1:0] m_data_reg;
    logic              out_free;
    logic              cfg_wr;
    reg_idx_t          idx;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_side    <= SIZE_W'(320);
            cfg_reg.max_side    <= SIZE_W'(640);
            cfg_reg.search_side <= SIZE_W'(640);
            cfg_reg.step_px     <= SIZE_W'(1);
            cfg_reg.alpha_q8    <= ALPHA_W'(64);
            cfg_reg.gain_q8     <= GAIN_W'(1707);
            cfg_reg.margin_q8   <= MARGIN_W'(0);
        end else if (cfg_wr) begin
            unique case (idx)
                REG_MIN_SIDE:    cfg_reg.min_side    <= pwdata[SIZE_W-1:0];
                REG_MAX_SIDE:    cfg_reg.max_side    <= pwdata[SIZE_W-1:0];
                REG_SEARCH_SIDE: cfg_reg.search_side <= pwdata[SIZE_W-1:0];
                REG_STEP_PX:     cfg_reg.step_px     <= pwdata[SIZE_W-1:0];
                REG_ALPHA_Q8:    cfg_reg.alpha_q8    <= pwdata[ALPHA_W-1:0];
                REG_GAIN_Q8:     cfg_reg.gain_q8     <= pwdata[GAIN_W-1:0];
                REG_MARGIN_Q8:   cfg_reg.margin_q8   <= pwdata[MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_MIN_SIDE:    prdata = APB_DW'(cfg_reg.min_side);
            REG_MAX_SIDE:    prdata = APB_DW'(cfg_reg.max_side);
            REG_SEARCH_SIDE: prdata = APB_DW'(cfg_reg.search_side);
            REG_STEP_PX:     prdata = APB_DW'(cfg_reg.step_px);
            REG_ALPHA_Q8:    prdata = APB_DW'(cfg_reg.alpha_q8);
            REG_GAIN_Q8:     prdata = APB_DW'(cfg_reg.gain_q8);
            REG_MARGIN_Q8:   prdata = APB_DW'(cfg_reg.margin_q8);
            default:         prdata = '0;
        endcase
    end

    always_comb begin
        item.box_left     = s_tdata[0*CB +: CB];
        item.box_top      = s_tdata[1*CB +: CB];
        item.box_right    = s_tdata[2*CB +: CB];
        item.box_bottom   = s_tdata[3*CB +: CB];
        item.win_left     = s_tdata[4*CB +: CB];
        item.win_top      = s_tdata[5*CB +: CB];
        item.win_width    = s_tdata[6*CB +: WB];
        item.win_height   = s_tdata[6*CB + WB +: WB];
        item.has_target   = s_tuser;
    end

    assign out_free = !m_tvalid_reg || m_tready;

    acsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd)
    );

    acsc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .item      (item),
        .cmd       (cmd),
        .sts       (sts),
        .crop_size (crop_size)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_data_reg <= crop_size;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TDATA_W'(m_data_reg);

    // A result is never written over one that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> out_free)
        else $error("result register overwritten while still pending");

    // Only one request is in flight at a time.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a request is still in work");

    // The clamped crop side is never zero.
    a_nonzero_crop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[SIZE_W-1:0] != '0))
        else $error("crop size of zero delivered");

    // A result only follows work on an accepted request.
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !s_tready)
        else $error("result produced while idle");

endmodule
